@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

@@ src/pale_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pale_pkg;

    localparam int unsigned DEPTH_DEF = 64;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned CNT_W   = 7;

    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 48;

    // commands
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

    // result status
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // datapath operations
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_DELETE = 3'd4;
    localparam logic [2:0] OP_ROTATE = 3'd5;

    typedef struct packed {
        logic [2:0]              op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
        logic                    load_out;
        logic [STAT_W-1:0]       out_status;
        logic [IDX_W-1:0]        out_idx;
        logic                    out_last;
        logic                    out_head;
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ src/positional_array_list_engine_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit entries held in a row of register
// cells. Clear, insert, update, delete and unknown commands finish in the cycle
// the item is accepted and give one result; insert and delete shift every later
// cell by one place in that same cycle. A dump of n entries gives n results,
// one per cycle while the output side takes them, by rotating the used cells
// so each entry in turn reaches cell 0; no input item is taken during a dump.
// A dump of an empty list gives one result with status empty. One result
// register sits on the output, so a new item is taken while a result waits as
// long as that result is taken in the same cycle.
module positional_array_list_engine_unit #(
    parameter int unsigned DEPTH = pale_pkg::DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // command[2:0], position[9:3], value[41:10], zero pad
    input  wire logic [pale_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // status[1:0], entry_index[7:2], entry_value[39:8], count_now[46:40], zero pad
    output logic [pale_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    output logic                                     o_m_axis_tlast
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [pale_pkg::CMD_W-1:0]        w_command;
    logic [pale_pkg::POS_W-1:0]        w_position;
    logic signed [pale_pkg::VAL_W-1:0] w_value;
    logic [CW-1:0]                     w_count;
    pale_pkg::t_dp_cmd                 w_cmd;

    logic [pale_pkg::STAT_W-1:0]       w_status;
    logic [pale_pkg::IDX_W-1:0]        w_entry_index;
    logic signed [pale_pkg::VAL_W-1:0] w_entry_value;
    logic [pale_pkg::CNT_W-1:0]        w_count_now;

    assign w_command  = i_s_axis_tdata[2:0];
    assign w_position = i_s_axis_tdata[9:3];
    assign w_value    = i_s_axis_tdata[41:10];

    pale_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_command   (w_command),
        .i_position  (w_position),
        .i_value     (w_value),
        .i_count     (w_count),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    pale_datapath #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_count       (w_count),
        .o_status      (w_status),
        .o_entry_index (w_entry_index),
        .o_entry_value (w_entry_value),
        .o_count_now   (w_count_now),
        .o_last        (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, w_count_now, w_entry_value, w_entry_index, w_status};

endmodule

`default_nettype wire

@@ src/pale_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pale_datapath #(
    parameter int unsigned DEPTH = pale_pkg::DEPTH_DEF,
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire pale_pkg::t_dp_cmd                  i_cmd,
    output logic [CW-1:0]                           o_count,
    output logic [pale_pkg::STAT_W-1:0]             o_status,
    output logic [pale_pkg::IDX_W-1:0]              o_entry_index,
    output logic signed [pale_pkg::VAL_W-1:0]       o_entry_value,
    output logic [pale_pkg::CNT_W-1:0]              o_count_now,
    output logic                                    o_last
);

    localparam int unsigned CMPW = (CW > pale_pkg::POS_W) ? CW : pale_pkg::POS_W;

    logic signed [pale_pkg::VAL_W-1:0] r_cell [DEPTH];
    logic signed [pale_pkg::VAL_W-1:0] n_cell [DEPTH];
    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     n_count;

    logic [CMPW-1:0] w_pos;
    assign w_pos = CMPW'(i_cmd.pos);

    // one cell per entry, each picks its neighbor, the new value or itself
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int unsigned GI = g;
        logic w_at_pos;
        logic w_above;
        logic w_at_end;
        assign w_at_pos = (w_pos == CMPW'(GI));
        assign w_above  = (w_pos < CMPW'(GI));
        assign w_at_end = ((CW'(GI) + CW'(1)) == r_count);

        always_comb begin
            n_cell[g] = r_cell[g];
            case (i_cmd.op)
                pale_pkg::OP_INSERT: begin
                    if (w_at_pos) begin
                        n_cell[g] = i_cmd.value;
                    end else if (w_above) begin
                        if (g > 0) begin
                            n_cell[g] = r_cell[(g > 0) ? g - 1 : 0];
                        end
                    end
                end
                pale_pkg::OP_UPDATE: begin
                    if (w_at_pos) begin
                        n_cell[g] = i_cmd.value;
                    end
                end
                pale_pkg::OP_DELETE: begin
                    if ((w_at_pos || w_above) && (g < DEPTH - 1)) begin
                        n_cell[g] = r_cell[(g < DEPTH - 1) ? g + 1 : g];
                    end
                end
                pale_pkg::OP_ROTATE: begin
                    // rotate the used entries so the next one reaches cell 0
                    if (w_at_end) begin
                        n_cell[g] = r_cell[0];
                    end else if (g < DEPTH - 1) begin
                        n_cell[g] = r_cell[(g < DEPTH - 1) ? g + 1 : g];
                    end
                end
                default: begin
                    n_cell[g] = r_cell[g];
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            r_cell[g] <= n_cell[g];
        end
    end

    always_comb begin
        n_count = r_count;
        case (i_cmd.op)
            pale_pkg::OP_CLEAR:  n_count = '0;
            pale_pkg::OP_INSERT: n_count = r_count + CW'(1);
            pale_pkg::OP_DELETE: n_count = r_count - CW'(1);
            default:             n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status      <= i_cmd.out_status;
            o_entry_index <= i_cmd.out_idx;
            o_entry_value <= i_cmd.out_head ? r_cell[0] : '0;
            o_count_now   <= pale_pkg::CNT_W'(n_count);
            o_last        <= i_cmd.out_last;
        end
    end

    assign o_count = r_count;

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(DEPTH))
    `ASSERT_CLK(a_insert_grows, i_clk, i_rst_n,
        (i_cmd.op == pale_pkg::OP_INSERT) |=> (r_count == $past(r_count) + CW'(1)))

endmodule

`default_nettype wire

@@ src/pale_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pale_ctrl #(
    parameter int unsigned DEPTH = pale_pkg::DEPTH_DEF,
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [pale_pkg::CMD_W-1:0]         i_command,
    input  wire logic [pale_pkg::POS_W-1:0]         i_position,
    input  wire logic signed [pale_pkg::VAL_W-1:0]  i_value,
    input  wire logic [CW-1:0]                      i_count,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output pale_pkg::t_dp_cmd                       o_cmd
);

    localparam int unsigned IW   = $clog2(DEPTH);
    localparam int unsigned CMPW = (CW > pale_pkg::POS_W) ? CW : pale_pkg::POS_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic          r_state;
    logic          n_state;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic          r_out_valid;
    logic          n_out_valid;

    logic w_slot_free;
    logic w_accept;
    logic w_full;
    logic w_empty;
    logic w_pos_gt;
    logic w_pos_ge;
    logic w_dump_last;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_full      = (i_count == CW'(DEPTH));
    assign w_empty     = (i_count == '0);
    assign w_pos_gt    = CMPW'(i_position) > CMPW'(i_count);
    assign w_pos_ge    = CMPW'(i_position) >= CMPW'(i_count);
    assign w_dump_last = ((CW'(r_idx) + CW'(1)) == i_count);

    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        o_cmd.op         = pale_pkg::OP_NONE;
        o_cmd.pos        = i_position;
        o_cmd.value      = i_value;
        o_cmd.load_out   = 1'b0;
        o_cmd.out_status = pale_pkg::ST_OK;
        o_cmd.out_idx    = '0;
        o_cmd.out_last   = 1'b1;
        o_cmd.out_head   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_out = 1'b1;
                    case (i_command)
                        pale_pkg::CMD_CLEAR: begin
                            o_cmd.op = pale_pkg::OP_CLEAR;
                        end
                        pale_pkg::CMD_INSERT: begin
                            if (w_full) begin
                                o_cmd.out_status = pale_pkg::ST_FULL;
                            end else if (w_pos_gt) begin
                                o_cmd.out_status = pale_pkg::ST_RANGE;
                            end else begin
                                o_cmd.op = pale_pkg::OP_INSERT;
                            end
                        end
                        pale_pkg::CMD_UPDATE: begin
                            if (w_pos_ge) begin
                                o_cmd.out_status = pale_pkg::ST_RANGE;
                            end else begin
                                o_cmd.op = pale_pkg::OP_UPDATE;
                            end
                        end
                        pale_pkg::CMD_DELETE: begin
                            if (w_empty) begin
                                o_cmd.out_status = pale_pkg::ST_EMPTY;
                            end else if (w_pos_ge) begin
                                o_cmd.out_status = pale_pkg::ST_RANGE;
                            end else begin
                                o_cmd.op = pale_pkg::OP_DELETE;
                            end
                        end
                        pale_pkg::CMD_DUMP: begin
                            if (w_empty) begin
                                o_cmd.out_status = pale_pkg::ST_EMPTY;
                            end else begin
                                // entries follow one per cycle from the dump state while the output side takes them
                                o_cmd.load_out = 1'b0;
                                n_state        = S_DUMP;
                                n_idx          = '0;
                            end
                        end
                        default: begin
                            o_cmd.op = pale_pkg::OP_NONE;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (w_slot_free) begin
                    o_cmd.op       = pale_pkg::OP_ROTATE;
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_idx  = pale_pkg::IDX_W'(r_idx);
                    o_cmd.out_last = w_dump_last;
                    o_cmd.out_head = 1'b1;
                    n_idx          = r_idx + IW'(1);
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_dump_idx_in_list, i_clk, i_rst_n,
        (r_state == S_DUMP) |-> (CW'(r_idx) < i_count))
    `ASSERT_CLK(a_dump_ends_idle, i_clk, i_rst_n,
        (r_state == S_DUMP && o_cmd.load_out && w_dump_last) |=> (r_state == S_IDLE))

endmodule

`default_nettype wire

@@ tb/tb_positional_array_list_engine_unit.sv @@
`timescale 1ns / 1ps

module tb_positional_array_list_engine_unit;

    localparam int unsigned LIST_DEPTH  = pale_pkg::DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned DRAIN_WAIT  = 20;
    localparam logic [pale_pkg::CMD_W-1:0] CMD_TOP = {pale_pkg::CMD_W{1'b1}};

    typedef struct {
        logic [pale_pkg::CMD_W-1:0]        cmd;
        logic [pale_pkg::POS_W-1:0]        pos;
        logic signed [pale_pkg::VAL_W-1:0] value;
        int unsigned                       gap;
    } t_list_cmd;

    typedef struct {
        logic [pale_pkg::STAT_W-1:0]       status;
        logic [pale_pkg::IDX_W-1:0]        idx;
        logic signed [pale_pkg::VAL_W-1:0] value;
        logic [pale_pkg::CNT_W-1:0]        count;
        logic                              last;
    } t_list_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [pale_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [pale_pkg::OUT_DATA_W-1:0] m_tdata;
    logic m_tlast;

    positional_array_list_engine_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // command, position, value, zero pad
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // status, entry_index, entry_value, count_now, zero pad
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_list_cmd    pending_cmds[$];
    t_list_result expected_results[$];

    // shadow copy of the list, advanced on every accepted item
    logic signed [pale_pkg::VAL_W-1:0] list_mem[LIST_DEPTH];
    int unsigned list_len = 0;

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned results_taken = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned gen_count = 0;
    bit item_taken = 0;
    bit result_taken = 0;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic predict_list_op(input t_list_cmd c);
        t_list_result r;
        int unsigned i;
        int unsigned p;
        r.status = pale_pkg::ST_OK;
        r.idx    = '0;
        r.value  = '0;
        r.last   = 1'b1;
        p = c.pos;
        case (c.cmd)
            pale_pkg::CMD_CLEAR: list_len = 0;
            pale_pkg::CMD_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = pale_pkg::ST_FULL;
                end else if (p > list_len) begin
                    r.status = pale_pkg::ST_RANGE;
                end else begin
                    for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p] = c.value;
                    list_len++;
                end
            end
            pale_pkg::CMD_UPDATE: begin
                if (p >= list_len) r.status = pale_pkg::ST_RANGE;
                else list_mem[p] = c.value;
            end
            pale_pkg::CMD_DELETE: begin
                if (list_len == 0) begin
                    r.status = pale_pkg::ST_EMPTY;
                end else if (p >= list_len) begin
                    r.status = pale_pkg::ST_RANGE;
                end else begin
                    for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            pale_pkg::CMD_DUMP: begin
                if (list_len == 0) r.status = pale_pkg::ST_EMPTY;
            end
            default: ;
        endcase
        r.count = list_len[pale_pkg::CNT_W-1:0];
        if (c.cmd == pale_pkg::CMD_DUMP && list_len != 0) begin
            for (i = 0; i < list_len; i++) begin
                r.idx   = i[pale_pkg::IDX_W-1:0];
                r.value = list_mem[i];
                r.last  = (i + 1 == list_len);
                expected_results.push_back(r);
            end
        end else begin
            expected_results.push_back(r);
        end
    endtask

    // stimulus helpers; gen_count follows the list length the stream should produce
    function automatic logic signed [pale_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [pale_pkg::POS_W-1:0] pick_pos(input int unsigned upper,
                                                             input bit has_valid);
        if (has_valid && $urandom_range(0, 99) < 85)
            return pale_pkg::POS_W'($urandom_range(0, upper));
        return pale_pkg::POS_W'($urandom_range(0, (1 << pale_pkg::POS_W) - 1));
    endfunction

    task automatic queue_cmd(input logic [pale_pkg::CMD_W-1:0] cmd,
                             input logic [pale_pkg::POS_W-1:0] pos,
                             input logic signed [pale_pkg::VAL_W-1:0] value);
        t_list_cmd c;
        c.cmd   = cmd;
        c.pos   = pos;
        c.value = value;
        // bursts with no gaps between stretches of random gaps
        c.gap   = (pending_cmds.size() % 50 < 15) ? 0 : $urandom_range(0, 16);
        case (cmd)
            pale_pkg::CMD_CLEAR: gen_count = 0;
            pale_pkg::CMD_INSERT: if (gen_count < LIST_DEPTH && pos <= gen_count) gen_count++;
            pale_pkg::CMD_DELETE: if (gen_count > 0 && pos < gen_count) gen_count--;
            default: ;
        endcase
        pending_cmds.push_back(c);
    endtask

    task automatic queue_random_cmd(input int unsigned insert_pct, input bit allow_clear);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            queue_cmd(pale_pkg::CMD_INSERT, pick_pos(gen_count, 1), pick_value());
        else if (r < insert_pct + (100 - insert_pct) * 30 / 100)
            queue_cmd(pale_pkg::CMD_UPDATE, pick_pos(gen_count - 1, gen_count != 0),
                      pick_value());
        else if (r < insert_pct + (100 - insert_pct) * 60 / 100)
            queue_cmd(pale_pkg::CMD_DELETE, pick_pos(gen_count - 1, gen_count != 0),
                      pick_value());
        else if (r < insert_pct + (100 - insert_pct) * 80 / 100)
            queue_cmd(pale_pkg::CMD_DUMP, pick_pos(0, 0), pick_value());
        else if (r < insert_pct + (100 - insert_pct) * 94 / 100)
            queue_cmd(pale_pkg::CMD_W'($urandom_range(pale_pkg::CMD_DUMP + 1, CMD_TOP)),
                      pick_pos(0, 0), pick_value());
        else if (allow_clear)
            queue_cmd(pale_pkg::CMD_CLEAR, pick_pos(0, 0), pick_value());
        else
            queue_cmd(pale_pkg::CMD_DUMP, pick_pos(0, 0), pick_value());
    endtask

    // input side: new item at a falling edge once the previous one was taken and its gap has run out
    always @(negedge i_clk) begin
        t_list_cmd c;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || item_taken) begin
            item_taken = 0;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                s_tdata  <= {{(pale_pkg::IN_DATA_W - pale_pkg::CMD_W - pale_pkg::POS_W
                               - pale_pkg::VAL_W){1'b0}}, c.value, c.pos, c.cmd};
                s_tvalid <= 1'b1;
                gap_left = pending_cmds.size() > 0 ? pending_cmds[0].gap : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output side: after each result, hold tready low for a random stall, except in runs with no stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (result_taken) begin
                result_taken = 0;
                stall_left = (results_taken % 64 < 20) ? 0 : $urandom_range(0, 16);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_list_cmd c;
        t_list_result e;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                c.cmd   = s_tdata[pale_pkg::CMD_W-1:0];
                c.pos   = s_tdata[pale_pkg::CMD_W +: pale_pkg::POS_W];
                c.value = s_tdata[pale_pkg::CMD_W + pale_pkg::POS_W +: pale_pkg::VAL_W];
                c.gap   = 0;
                predict_list_op(c);
                item_taken = 1;
            end
            if (m_tvalid && m_tready) begin
                result_taken = 1;
                results_taken++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata[1:0] !== e.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_tdata[1:0], e.status));
                    if (m_tdata[7:2] !== e.idx)
                        report_mismatch($sformatf("entry_index %0d, want %0d",
                                                  m_tdata[7:2], e.idx));
                    if (m_tdata[39:8] !== e.value)
                        report_mismatch($sformatf("entry_value %h, want %h",
                                                  m_tdata[39:8], e.value));
                    if (m_tdata[46:40] !== e.count)
                        report_mismatch($sformatf("count_now %0d, want %0d",
                                                  m_tdata[46:40], e.count));
                    if (m_tlast !== e.last)
                        report_mismatch($sformatf("last %b, want %b", m_tlast, e.last));
                end
            end
        end
    end

    initial begin
        int unsigned n;
        // directed: empty-list cases, edits at front, middle and end, bad positions
        queue_cmd(pale_pkg::CMD_DUMP,   7'd0,   32'sh0);
        queue_cmd(pale_pkg::CMD_DELETE, 7'd0,   32'sh0);
        queue_cmd(pale_pkg::CMD_UPDATE, 7'd0,   32'sh1234_5678);
        queue_cmd(pale_pkg::CMD_INSERT, 7'd1,   32'sh1);
        queue_cmd(pale_pkg::CMD_INSERT, 7'd0,   32'sh7FFF_FFFF);
        queue_cmd(pale_pkg::CMD_INSERT, 7'd0,   32'sh8000_0000);
        queue_cmd(pale_pkg::CMD_INSERT, 7'd2,   -32'sd1);
        queue_cmd(pale_pkg::CMD_INSERT, 7'd1,   32'sh0);
        queue_cmd(pale_pkg::CMD_UPDATE, 7'd3,   32'sh5555_5555);
        queue_cmd(pale_pkg::CMD_UPDATE, 7'd4,   32'shAAAA_AAAA);
        queue_cmd(pale_pkg::CMD_INSERT, 7'd127, 32'sh2);
        queue_cmd(pale_pkg::CMD_DUMP,   7'd0,   32'sh0);
        queue_cmd(pale_pkg::CMD_DELETE, 7'd4,   32'sh0);
        queue_cmd(pale_pkg::CMD_DELETE, 7'd127, 32'sh0);
        queue_cmd(pale_pkg::CMD_DELETE, 7'd1,   32'sh0);
        queue_cmd(pale_pkg::CMD_DELETE, 7'd2,   32'sh0);
        queue_cmd(pale_pkg::CMD_DELETE, 7'd0,   32'sh0);
        for (n = pale_pkg::CMD_DUMP + 1; n <= CMD_TOP; n++)
            queue_cmd(n[pale_pkg::CMD_W-1:0], 7'd127, -32'sd1);
        queue_cmd(pale_pkg::CMD_DUMP,   7'd0,   32'sh0);
        queue_cmd(pale_pkg::CMD_CLEAR,  7'd0,   32'sh0);
        queue_cmd(pale_pkg::CMD_DUMP,   7'd0,   32'sh0);
        queue_cmd(pale_pkg::CMD_CLEAR,  7'd127, -32'sd1);

        // fill to the top with other commands mixed in, then hit the full list
        while (gen_count < LIST_DEPTH) queue_random_cmd(85, 1'b0);
        queue_cmd(pale_pkg::CMD_INSERT, 7'd64, pick_value());
        queue_cmd(pale_pkg::CMD_INSERT, 7'd0, pick_value());
        queue_cmd(pale_pkg::CMD_INSERT, 7'd127, pick_value());
        queue_cmd(pale_pkg::CMD_UPDATE, 7'd63, pick_value());
        queue_cmd(pale_pkg::CMD_UPDATE, 7'd64, pick_value());
        queue_cmd(pale_pkg::CMD_DUMP, 7'd0, 32'sh0);
        queue_cmd(pale_pkg::CMD_DELETE, 7'd64, 32'sh0);
        queue_cmd(pale_pkg::CMD_DELETE, 7'd63, 32'sh0);

        // mixed traffic with clears mixed in, so the length wanders
        for (n = 0; n < 80; n++) queue_random_cmd(40, 1'b1);
        queue_cmd(pale_pkg::CMD_DUMP, 7'd0, 32'sh0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
